// File: hw/rtl/eight_bit_ttl_cpu_cycle_macros.svh
// Assertion macros shared by the CPU cycle RTL.
`ifndef EIGHT_BIT_TTL_CPU_CYCLE_MACROS_SVH
`define EIGHT_BIT_TTL_CPU_CYCLE_MACROS_SVH

// Checked outside reset only.
`define ETTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ETTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ettc_pkg.sv
// Shared types and opcode field codes for the CPU cycle block.
package ettc_pkg;

  localparam int RAM_ADDR_BITS_DEFAULT = 15;

  // operation field, opcode bits 7..5
  localparam logic [2:0] OP_LD  = 3'd0;
  localparam logic [2:0] OP_AND = 3'd1;
  localparam logic [2:0] OP_OR  = 3'd2;
  localparam logic [2:0] OP_XOR = 3'd3;
  localparam logic [2:0] OP_ADD = 3'd4;
  localparam logic [2:0] OP_SUB = 3'd5;
  localparam logic [2:0] OP_ST  = 3'd6;
  localparam logic [2:0] OP_JMP = 3'd7;

  // mode field, opcode bits 4..2
  localparam logic [2:0] MODE_D      = 3'd0;
  localparam logic [2:0] MODE_X      = 3'd1;
  localparam logic [2:0] MODE_YD     = 3'd2;
  localparam logic [2:0] MODE_YX     = 3'd3;
  localparam logic [2:0] MODE_XREG   = 3'd4;
  localparam logic [2:0] MODE_YREG   = 3'd5;
  localparam logic [2:0] MODE_OUT    = 3'd6;
  localparam logic [2:0] MODE_OUTINC = 3'd7;

  // bus source field, opcode bits 1..0
  localparam logic [1:0] SRC_D   = 2'd0;
  localparam logic [1:0] SRC_RAM = 2'd1;
  localparam logic [1:0] SRC_AC  = 2'd2;
  localparam logic [1:0] SRC_IN  = 2'd3;

  // result word, fetch address in the low bits
  typedef struct packed {
    logic [7:0]  index_y;
    logic [7:0]  index_x;
    logic [7:0]  accumulator;
    logic [7:0]  output_value;
    logic [15:0] fetch_address;
  } result_t;

endpackage

// File: hw/rtl/ettc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ettc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ettc_skid.sv
// Two-entry output buffer for result words.
module ettc_skid import ettc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    spare_valid;
  result_t spare;
  logic    pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        out_data    <= spare;
        spare_valid <= 1'b0;
      end else if (in_valid) begin
        out_data <= in_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        spare       <= in_data;
        spare_valid <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ettc_core.sv
// Execute stage: architectural registers, data RAM, clear sweep and next-state logic.
`include "eight_bit_ttl_cpu_cycle_macros.svh"
module ettc_core import ettc_pkg::*; #(
  parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rom_opcode,
  input  logic [7:0] rom_operand,
  input  logic [7:0] in_port,
  input  logic       res_ready,
  output logic       res_valid,
  output result_t    res
);

  localparam int RamDepth = 2 ** RAM_ADDR_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  function automatic logic [15:0] ram_addr(input logic [7:0] ins, input logic [7:0] opr,
                                           input logic [7:0] xv, input logic [7:0] yv);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = opr;
    hi = 8'h00;
    if (ins[7:5] != OP_JMP) begin
      case (ins[4:2])
        MODE_X: lo = xv;
        MODE_YD: hi = yv;
        MODE_YX, MODE_OUTINC: begin
          lo = xv;
          hi = yv;
        end
        default: ;
      endcase
    end
    return {hi, lo};
  endfunction

  state_t                   state;
  logic [RAM_ADDR_BITS-1:0] clr_cnt;
  logic [7:0]               fbv;

  logic [15:0] pc;
  logic [7:0]  ir;
  logic [7:0]  opr;
  logic [7:0]  acc;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  outr;

  logic [15:0] pc_next;
  logic [7:0]  acc_next;
  logic [7:0]  x_next;
  logic [7:0]  y_next;
  logic [7:0]  out_next;

  logic       accept;
  logic [2:0] op;
  logic [2:0] mode;
  logic [1:0] src;
  logic       is_st;
  logic       is_jmp;
  logic       ld_acc;
  logic       ld_x;
  logic       ld_y;
  logic       ld_out;
  logic       inc_x;
  logic       taken;
  logic [7:0] bus;
  logic [7:0] alu;
  logic [7:0] ram_q;
  logic [7:0] ram_rd;
  logic       fwd;
  logic [7:0] fwd_data;

  logic [15:0]              addr_cur;
  logic [15:0]              addr_nxt;
  logic [RAM_ADDR_BITS-1:0] ram_waddr;
  logic [RAM_ADDR_BITS-1:0] ram_raddr;
  logic [7:0]               ram_wdata;
  logic                     ram_we;

  assign in_ready = (state == ST_RUN) && res_ready;
  assign accept   = in_valid && in_ready;

  assign op     = ir[7:5];
  assign mode   = ir[4:2];
  assign src    = ir[1:0];
  assign is_st  = (op == OP_ST);
  assign is_jmp = (op == OP_JMP);

  always_comb begin
    ld_acc = 1'b0;
    ld_x   = 1'b0;
    ld_y   = 1'b0;
    ld_out = 1'b0;
    inc_x  = 1'b0;
    if (!is_jmp) begin
      case (mode)
        MODE_D, MODE_X, MODE_YD, MODE_YX: ld_acc = !is_st;
        MODE_XREG: ld_x = 1'b1;
        MODE_YREG: ld_y = 1'b1;
        MODE_OUT: ld_out = !is_st;
        MODE_OUTINC: begin
          ld_out = !is_st;
          inc_x  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign addr_cur = ram_addr(ir, opr, x, y);
  assign ram_rd   = fwd ? fwd_data : ram_q;

  always_comb begin
    case (src)
      SRC_D:   bus = opr;
      SRC_RAM: bus = is_st ? fbv : ram_rd;
      SRC_AC:  bus = acc;
      default: bus = in_port;
    endcase
  end

  always_comb begin
    case (op)
      OP_LD:   alu = bus;
      OP_AND:  alu = acc & bus;
      OP_OR:   alu = acc | bus;
      OP_XOR:  alu = acc ^ bus;
      OP_ADD:  alu = acc + bus;
      OP_SUB:  alu = acc - bus;
      OP_ST:   alu = acc;
      default: alu = 8'h00 - acc;
    endcase
  end

  // branch condition: zero picks mode bit 2, negative bit 1, positive bit 0
  assign taken = (acc == 8'h00) ? mode[2] : (acc[7] ? mode[1] : mode[0]);

  always_comb begin
    acc_next = ld_acc ? alu : acc;
    y_next   = ld_y ? alu : y;
    out_next = ld_out ? alu : outr;
    if (inc_x) begin
      x_next = x + 8'd1;
    end else if (ld_x) begin
      x_next = alu;
    end else begin
      x_next = x;
    end
    pc_next = pc + 16'd1;
    if (is_jmp) begin
      if (mode == MODE_D) begin
        pc_next = {y, bus};
      end else if (taken) begin
        pc_next = {pc[15:8], bus};
      end
    end
  end

  assign addr_nxt = ram_addr(rom_opcode, rom_operand, x_next, y_next);

  assign ram_raddr = accept ? addr_nxt[RAM_ADDR_BITS-1:0] : addr_cur[RAM_ADDR_BITS-1:0];
  assign ram_we    = (state == ST_CLEAR) || (accept && is_st);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : addr_cur[RAM_ADDR_BITS-1:0];
  assign ram_wdata = (state == ST_CLEAR) ? 8'h00 : bus;

  ettc_ram #(
    .WIDTH(8),
    .DEPTH(RamDepth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      fbv     <= 8'h00;
      fwd     <= 1'b0;
      pc      <= 16'h0000;
      ir      <= 8'h00;
      opr     <= 8'h00;
      acc     <= 8'h00;
      x       <= 8'h00;
      y       <= 8'h00;
      outr    <= 8'h00;
    end else begin
      if (cfg_wr_en) begin
        fbv <= cfg_wr_data;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
      // store followed by a read of the same byte: RAM returns old data
      fwd      <= accept && is_st &&
                  (addr_nxt[RAM_ADDR_BITS-1:0] == addr_cur[RAM_ADDR_BITS-1:0]);
      fwd_data <= bus;
      if (accept) begin
        pc   <= pc_next;
        ir   <= rom_opcode;
        opr  <= rom_operand;
        acc  <= acc_next;
        x    <= x_next;
        y    <= y_next;
        outr <= out_next;
      end
    end
  end

  assign res_valid = accept;
  assign res       = '{index_y: y_next, index_x: x_next, accumulator: acc_next,
                       output_value: out_next, fetch_address: pc_next};

  `ETTC_ASSERT(a_no_accept_in_clear, (state == ST_CLEAR) |-> !accept, "accept during clear")
  `ETTC_ASSERT(a_clear_ends, (state == ST_CLEAR && &clr_cnt) |=> state == ST_RUN, "clear stuck")
  `ETTC_ASSERT(a_pc_step, (accept && !is_jmp) |=> (pc == $past(pc) + 16'd1), "pc not advanced")
  `ETTC_ASSERT(a_fwd_source, fwd |-> $past(accept && is_st), "forward without store")
  `ETTC_ASSERT_ALWAYS(a_reset_clear, rst |=> (state == ST_CLEAR && !in_ready), "no clear")

endmodule

// File: hw/rtl/eight_bit_ttl_cpu_cycle.sv
// Output: each result word is registered in the output buffer before it shows on m_axis.
// Throughput: one word per cycle while the output buffer has room; the execute path is a single registered pass.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Reset: rst (synchronous) zeroes the CPU registers, then the data RAM is cleared
// one byte per cycle, all 2**RAM_ADDR_BITS bytes, with s_axis_tready low.
module eight_bit_ttl_cpu_cycle import ettc_pkg::*; #(
  parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // floating_bus_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // rom_opcode, rom_operand, in_port
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata     // fetch_address, output_value, accumulator, index_x, index_y
);

  logic    skid_ready;
  logic    res_valid;
  result_t res;
  result_t res_out;

  ettc_core #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .rom_opcode (s_axis_tdata[7:0]),
    .rom_operand(s_axis_tdata[15:8]),
    .in_port    (s_axis_tdata[23:16]),
    .res_ready  (skid_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  ettc_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res),
    .in_ready (skid_ready),
    .out_valid(m_axis_tvalid),
    .out_data (res_out),
    .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = res_out;

endmodule

// File: bench/eight_bit_ttl_cpu_cycle_tb.sv
// Self-checking stream testbench for the TTL CPU cycle block: predicts the registers after every accepted word.
module eight_bit_ttl_cpu_cycle_tb import ettc_pkg::*; ();

  localparam int RAM_BITS    = RAM_ADDR_BITS_DEFAULT;
  localparam int RAM_WORDS   = 1 << RAM_BITS;
  localparam int STALL_LIMIT = 100000;
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_WORDS = 240;

  // jump conditions, mode field of a jump
  localparam logic [2:0] BR_FAR    = 3'd0;
  localparam logic [2:0] BR_GT     = 3'd1;
  localparam logic [2:0] BR_LT     = 3'd2;
  localparam logic [2:0] BR_EQ     = 3'd4;
  localparam logic [2:0] BR_ALWAYS = 3'd7;

  typedef enum logic [2:0] {DST_NONE, DST_AC, DST_X, DST_Y, DST_OUT} dest_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'h0;  // rom_opcode, rom_operand, in_port
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;          // fetch_address, output_value, accumulator, index_x, index_y

  eight_bit_ttl_cpu_cycle DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // CPU model state
  logic [15:0] reg_pc = '0;
  logic [7:0]  cur_insn = '0;
  logic [7:0]  cur_operand = '0;
  logic [7:0]  reg_ac = '0;
  logic [7:0]  reg_x = '0;
  logic [7:0]  reg_y = '0;
  logic [7:0]  reg_out = '0;
  logic [7:0]  floating_bus = '0;
  logic [7:0]  data_ram [RAM_WORDS];

  logic [23:0] rom_words [$];
  result_t     states_due [$];

  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int fail_count = 0;
  int idle_run = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  bit word_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic execute_insn(input logic [23:0] word, output result_t res);
    logic [2:0] op, mode;
    logic [1:0] src;
    logic is_store, is_jump, inc_x;
    logic [7:0] lo, hi, bus, alu, old_ac, old_x, old_y;
    logic [15:0] old_pc;
    logic [RAM_BITS-1:0] addr;
    dest_t dst;
    int cond;
    op = cur_insn[7:5];
    mode = cur_insn[4:2];
    src = cur_insn[1:0];
    is_store = (op == OP_ST);
    is_jump = (op == OP_JMP);
    lo = cur_operand;
    hi = 8'h00;
    dst = DST_NONE;
    inc_x = 1'b0;
    if (!is_jump) begin
      case (mode)
        MODE_D: dst = is_store ? DST_NONE : DST_AC;
        MODE_X: begin
          dst = is_store ? DST_NONE : DST_AC;
          lo = reg_x;
        end
        MODE_YD: begin
          dst = is_store ? DST_NONE : DST_AC;
          hi = reg_y;
        end
        MODE_YX: begin
          dst = is_store ? DST_NONE : DST_AC;
          lo = reg_x;
          hi = reg_y;
        end
        MODE_XREG: dst = DST_X;
        MODE_YREG: dst = DST_Y;
        MODE_OUT: dst = is_store ? DST_NONE : DST_OUT;
        default: begin
          dst = is_store ? DST_NONE : DST_OUT;
          lo = reg_x;
          hi = reg_y;
          inc_x = 1'b1;
        end
      endcase
    end
    addr = RAM_BITS'({hi, lo});
    case (src)
      SRC_D: bus = cur_operand;
      SRC_RAM: bus = is_store ? floating_bus : data_ram[addr];
      SRC_AC: bus = reg_ac;
      default: bus = word[23:16];
    endcase
    if (is_store) data_ram[addr] = bus;
    case (op)
      OP_LD: alu = bus;
      OP_AND: alu = reg_ac & bus;
      OP_OR: alu = reg_ac | bus;
      OP_XOR: alu = reg_ac ^ bus;
      OP_ADD: alu = reg_ac + bus;
      OP_SUB: alu = reg_ac - bus;
      OP_ST: alu = reg_ac;
      default: alu = 8'h00 - reg_ac;
    endcase
    old_ac = reg_ac;
    old_x = reg_x;
    old_y = reg_y;
    old_pc = reg_pc;
    case (dst)
      DST_AC: reg_ac = alu;
      DST_X: reg_x = alu;
      DST_Y: reg_y = alu;
      DST_OUT: reg_out = alu;
      default: ;
    endcase
    if (inc_x) reg_x = old_x + 8'd1;
    reg_pc = old_pc + 16'd1;
    if (is_jump) begin
      if (mode == BR_FAR) begin
        reg_pc = {old_y, bus};
      end else begin
        // bit 0 gt, bit 1 lt, bit 2 eq
        cond = int'(old_ac[7]) + ((old_ac == 8'h00) ? 2 : 0);
        if (mode[cond]) reg_pc = {old_pc[15:8], bus};
      end
    end
    cur_insn = word[7:0];
    cur_operand = word[15:8];
    res.fetch_address = reg_pc;
    res.output_value = reg_out;
    res.accumulator = reg_ac;
    res.index_x = reg_x;
    res.index_y = reg_y;
  endtask

  // input side: hold each word until taken, random gaps between words
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || word_taken)) begin
      if (rom_words.size() != 0 && $urandom_range(1, 100) > sender_idle_pct) begin
        s_axis_tdata <= rom_words.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) > receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_t got, want, next_state;
    bit in_fire, out_fire;
    if (!rst) begin
      in_fire = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (out_fire) begin
        got = m_axis_tdata;
        if (states_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          want = states_due.pop_front();
          results_checked++;
          if (got.fetch_address !== want.fetch_address ||
              got.output_value !== want.output_value ||
              got.accumulator !== want.accumulator || got.index_x !== want.index_x ||
              got.index_y !== want.index_y) begin
            fail_count++;
            if (fail_count <= 10)
              $display("word %0d: pc %h/%h out %h/%h ac %h/%h x %h/%h y %h/%h (exp/got)",
                       results_checked, want.fetch_address, got.fetch_address,
                       want.output_value, got.output_value, want.accumulator,
                       got.accumulator, want.index_x, got.index_x, want.index_y,
                       got.index_y);
          end
        end
      end
      word_taken = in_fire;
      if (in_fire) begin
        execute_insn(s_axis_tdata, next_state);
        states_due.push_back(next_state);
        items_accepted++;
      end
      if (in_fire || out_fire) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", idle_run);
          $display("eight_bit_ttl_cpu_cycle regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic queue_word(input logic [23:0] word);
    rom_words.push_back(word);
    items_queued++;
  endtask

  task automatic queue_insn(input logic [2:0] op, input logic [2:0] mode, input logic [1:0] src,
                            input logic [7:0] operand, input logic [7:0] inport);
    queue_word({inport, operand, op, mode, src});
  endtask

  // small operands half the time so stores and loads hit the same bytes
  function automatic logic [23:0] random_word();
    logic [7:0] opd;
    opd = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    return {8'($urandom_range(0, 255)), opd, 8'($urandom_range(0, 255))};
  endfunction

  task automatic set_floating_bus(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    floating_bus = value;
  endtask

  task automatic drain();
    while (items_accepted != items_queued || states_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int send_pct, input int stall_pct, input logic [7:0] fbus);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    set_floating_bus(fbus);
    repeat (RANDOM_WORDS) queue_word(random_word());
    drain();
  endtask

  initial begin
    for (int i = 0; i < RAM_WORDS; i++) data_ram[i] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_floating_bus(8'hA5);
    queue_insn(OP_LD, MODE_D, SRC_D, 8'h80, 8'h00);
    queue_insn(OP_ST, MODE_D, SRC_AC, 8'h10, 8'hFF);
    queue_insn(OP_LD, MODE_D, SRC_RAM, 8'h10, 8'h00);
    queue_insn(OP_ST, MODE_D, SRC_RAM, 8'h11, 8'h5A);     // undriven bus store
    queue_insn(OP_LD, MODE_D, SRC_RAM, 8'h11, 8'h00);
    queue_insn(OP_LD, MODE_YREG, SRC_D, 8'h80, 8'h00);
    queue_insn(OP_LD, MODE_YD, SRC_RAM, 8'h11, 8'h00);    // 0x8011 aliases 0x0011
    queue_insn(OP_LD, MODE_XREG, SRC_D, 8'hFF, 8'h00);
    queue_insn(OP_ST, MODE_OUTINC, SRC_IN, 8'h00, 8'h3C); // x wraps
    queue_insn(OP_ST, MODE_XREG, SRC_D, 8'h22, 8'hC3);
    queue_insn(OP_ST, MODE_YREG, SRC_D, 8'h33, 8'h00);
    queue_insn(OP_ADD, MODE_D, SRC_D, 8'hFF, 8'h00);
    queue_insn(OP_SUB, MODE_D, SRC_D, 8'hFF, 8'h00);
    queue_insn(OP_AND, MODE_D, SRC_IN, 8'h00, 8'hF0);
    queue_insn(OP_OR, MODE_X, SRC_AC, 8'h00, 8'h0F);
    queue_insn(OP_XOR, MODE_YX, SRC_RAM, 8'h00, 8'h00);
    queue_insn(OP_LD, MODE_OUT, SRC_IN, 8'h00, 8'hA5);
    queue_insn(OP_LD, MODE_OUTINC, SRC_D, 8'h7E, 8'h00);
    queue_insn(OP_JMP, BR_FAR, SRC_D, 8'h34, 8'h00);
    queue_insn(OP_LD, MODE_D, SRC_D, 8'h00, 8'h00);
    queue_insn(OP_JMP, BR_EQ, SRC_D, 8'h40, 8'h00);
    queue_insn(OP_JMP, BR_GT, SRC_D, 8'h50, 8'h00);
    queue_insn(OP_LD, MODE_D, SRC_D, 8'hFF, 8'h00);
    queue_insn(OP_JMP, BR_LT, SRC_D, 8'h70, 8'h00);
    queue_insn(OP_JMP, BR_ALWAYS, SRC_RAM, 8'h10, 8'h00);
    queue_word(24'hFFFFFF);
    queue_word(24'h000000);
    drain();

    run_random(0, 0, 8'h00);
    run_random(70, 0, 8'hFF);
    run_random(0, 70, 8'($urandom_range(0, 255)));
    run_random(34, 34, 8'($urandom_range(0, 255)));

    // long output hold while input keeps coming
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_floating_bus(8'($urandom_range(0, 255)));
    repeat (200) queue_word(random_word());
    while (items_accepted < items_queued - 180) @(posedge clk);
    holds_asked++;
    drain();

    fail_count += states_due.size();
    $display("ran %0d instruction words, %0d register snapshots checked,", items_accepted,
             results_checked);
    $display("all ops, modes, bus sources, branch conditions and several floating bus values");
    if (fail_count == 0) begin
      $display("eight_bit_ttl_cpu_cycle regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("eight_bit_ttl_cpu_cycle regression: fail");
    end
    $finish;
  end

endmodule
